// ===== sv/sctd_pkg.sv =====
// ----------------------------------------------------------------------------
// sctd_pkg
// Shared types, constants and microcode encoding for the seconds to calendar
// date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sctd_pkg;

    // Time constants
    localparam logic [31:0] EPOCH_SHIFT_UNIX = 32'h83AA_7E80;
    localparam logic [31:0] COMMON_YEAR_LEN  = 32'd31536000;
    localparam logic [31:0] LEAP_YEAR_LEN    = 32'd31622400;
    localparam logic [16:0] SEC_PER_DAY      = 17'd86400;
    localparam logic [16:0] SEC_PER_HOUR     = 17'd3600;
    localparam logic [16:0] SEC_PER_MIN      = 17'd60;
    localparam logic [10:0] BASE_YEAR        = 11'd1900;
    localparam logic [16:0] ZONE_RESET       = 17'sd28800;

    // 1900 mod 400
    localparam logic [8:0]  BASE_MOD400      = 9'd300;

    // Month lengths in seconds (all below 2^22)
    localparam int          MSEC_W           = 22;
    localparam logic [MSEC_W-1:0] MSEC_31    = 22'd2678400;
    localparam logic [MSEC_W-1:0] MSEC_30    = 22'd2592000;
    localparam logic [MSEC_W-1:0] MSEC_29    = 22'd2505600;
    localparam logic [MSEC_W-1:0] MSEC_28    = 22'd2419200;

    localparam logic [3:0]  MONTH_JAN        = 4'd1;
    localparam logic [3:0]  MONTH_FEB        = 4'd2;
    localparam logic [3:0]  MONTH_DEC        = 4'd12;

    // Microcode store size
    localparam int          UC_DEPTH         = 19;
    localparam int          PC_W             = $clog2(UC_DEPTH);

    typedef enum logic [1:0] {
        OP_YEAR,
        OP_MONTH,
        OP_DIV,
        OP_DONE
    } t_op;

    typedef enum logic [1:0] {
        DST_DAY,
        DST_HOUR,
        DST_MIN
    } t_dst;

    // One microcode control word
    typedef struct packed {
        t_op             op;
        t_dst            dst;
        logic [2:0]      shamt;
        logic [PC_W-1:0] target;
        logic            halt;
    } t_ucode;

    // Sequencer to datapath
    typedef struct packed {
        logic   busy;
        logic   load;
        t_ucode uc;
    } t_ctl;

    // Datapath to sequencer
    typedef struct packed {
        logic cond;
    } t_stat;

    // Seconds in a given month, leap aware
    function automatic logic [MSEC_W-1:0] month_secs(input logic [3:0] month,
                                                      input logic       leap);
        logic [MSEC_W-1:0] len;
        case (month)
            4'd4, 4'd6, 4'd9, 4'd11: len = MSEC_30;
            MONTH_FEB:               len = leap ? MSEC_29 : MSEC_28;
            default:                 len = MSEC_31;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== sv/seconds_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// seconds_to_calendar_date
// Converts an NTP or Unix seconds count plus a local zone offset into the
// Gregorian year, month, day, hour, minute and second.
//
// Usage:
//   Input channel  i_in_valid / o_in_stall carries i_seconds_count and
//   i_epoch_select; a transaction completes when valid is high and stall low.
//   Output channel o_out_valid / i_out_stall carries the six date fields.
//   i_cfg_wr_en writes i_cfg_wr_data into the signed zone offset register;
//   write it only while no conversion is in flight.
//   The year loop takes off whole years past 1900 (up to 136), the month
//   loop whole months (up to 11), then 16 division steps and one hand-off
//   step follow; the year loop bounds the time from acceptance to o_out_valid.
//   One conversion runs at a time; o_in_stall is high from acceptance through
//   the hand-off step, so no new one is taken until the run ends. The next
//   one can be taken while the previous result still waits for the receiver.
//   If the receiver stalls, the hand-off step waits and the result holds.
//   Reset clears the sequencer and output valid and sets the offset to 28800.
// ----------------------------------------------------------------------------
`default_nettype none

module seconds_to_calendar_date
    import sctd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [16:0] i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_seconds_count,
    input  wire logic        i_epoch_select,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [10:0]      o_year_value,
    output logic [3:0]       o_month_value,
    output logic [4:0]       o_day_value,
    output logic [4:0]       o_hour_value,
    output logic [5:0]       o_minute_value,
    output logic [5:0]       o_second_value
);

    logic [16:0]     r_zone;
    logic [PC_W-1:0] pc;
    t_ucode          uc;
    t_stat           stat;
    t_ctl            ctl;

    // Zone offset register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= ZONE_RESET;
        end else if (i_cfg_wr_en) begin
            r_zone <= i_cfg_wr_data;
        end
    end

    sctd_ucode_rom u_rom (
        .i_pc (pc),
        .o_uc (uc)
    );

    sctd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_pc       (pc),
        .i_uc       (uc),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    sctd_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .o_stat          (stat),
        .i_seconds_count (i_seconds_count),
        .i_epoch_select  (i_epoch_select),
        .i_zone          (r_zone),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_year_value    (o_year_value),
        .o_month_value   (o_month_value),
        .o_day_value     (o_day_value),
        .o_hour_value    (o_hour_value),
        .o_minute_value  (o_minute_value),
        .o_second_value  (o_second_value)
    );

    // A result only appears after the hand-off step of a run
    a_result_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(ctl.busy && uc.op == OP_DONE))
        else $error("seconds_to_calendar_date: result without a finished run");

    // No transaction is taken while a run is in progress
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.load |-> !ctl.busy)
        else $error("seconds_to_calendar_date: accepted during a run");

    // A run always starts at the year loop
    a_start_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.load |=> (ctl.busy && pc == '0))
        else $error("seconds_to_calendar_date: run did not start at step zero");

endmodule

`default_nettype wire

// ===== sv/sctd_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// sctd_ucode_rom
// Read-only microprogram: year loop, month loop, three restoring divisions
// (day, hour, minute) and the result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module sctd_ucode_rom
    import sctd_pkg::*;
(
    input  wire logic [PC_W-1:0] i_pc,
    output t_ucode               o_uc
);

    localparam logic [PC_W-1:0] PC_YEAR  = PC_W'(0);
    localparam logic [PC_W-1:0] PC_MONTH = PC_W'(1);
    localparam logic [PC_W-1:0] PC_DONE  = PC_W'(18);

    // Program: loops jump to themselves while their condition holds
    always_comb begin
        o_uc = '{op: OP_DONE, dst: DST_DAY, shamt: 3'd0, target: PC_DONE, halt: 1'b1};
        case (i_pc)
            5'd0:  o_uc = '{op: OP_YEAR,  dst: DST_DAY,  shamt: 3'd0, target: PC_YEAR,  halt: 1'b0};
            5'd1:  o_uc = '{op: OP_MONTH, dst: DST_DAY,  shamt: 3'd0, target: PC_MONTH, halt: 1'b0};
            // day quotient, 5 bits
            5'd2:  o_uc = '{op: OP_DIV,   dst: DST_DAY,  shamt: 3'd4, target: PC_YEAR,  halt: 1'b0};
            5'd3:  o_uc = '{op: OP_DIV,   dst: DST_DAY,  shamt: 3'd3, target: PC_YEAR,  halt: 1'b0};
            5'd4:  o_uc = '{op: OP_DIV,   dst: DST_DAY,  shamt: 3'd2, target: PC_YEAR,  halt: 1'b0};
            5'd5:  o_uc = '{op: OP_DIV,   dst: DST_DAY,  shamt: 3'd1, target: PC_YEAR,  halt: 1'b0};
            5'd6:  o_uc = '{op: OP_DIV,   dst: DST_DAY,  shamt: 3'd0, target: PC_YEAR,  halt: 1'b0};
            // hour quotient, 5 bits
            5'd7:  o_uc = '{op: OP_DIV,   dst: DST_HOUR, shamt: 3'd4, target: PC_YEAR,  halt: 1'b0};
            5'd8:  o_uc = '{op: OP_DIV,   dst: DST_HOUR, shamt: 3'd3, target: PC_YEAR,  halt: 1'b0};
            5'd9:  o_uc = '{op: OP_DIV,   dst: DST_HOUR, shamt: 3'd2, target: PC_YEAR,  halt: 1'b0};
            5'd10: o_uc = '{op: OP_DIV,   dst: DST_HOUR, shamt: 3'd1, target: PC_YEAR,  halt: 1'b0};
            5'd11: o_uc = '{op: OP_DIV,   dst: DST_HOUR, shamt: 3'd0, target: PC_YEAR,  halt: 1'b0};
            // minute quotient, 6 bits; remainder is the second
            5'd12: o_uc = '{op: OP_DIV,   dst: DST_MIN,  shamt: 3'd5, target: PC_YEAR,  halt: 1'b0};
            5'd13: o_uc = '{op: OP_DIV,   dst: DST_MIN,  shamt: 3'd4, target: PC_YEAR,  halt: 1'b0};
            5'd14: o_uc = '{op: OP_DIV,   dst: DST_MIN,  shamt: 3'd3, target: PC_YEAR,  halt: 1'b0};
            5'd15: o_uc = '{op: OP_DIV,   dst: DST_MIN,  shamt: 3'd2, target: PC_YEAR,  halt: 1'b0};
            5'd16: o_uc = '{op: OP_DIV,   dst: DST_MIN,  shamt: 3'd1, target: PC_YEAR,  halt: 1'b0};
            5'd17: o_uc = '{op: OP_DIV,   dst: DST_MIN,  shamt: 3'd0, target: PC_YEAR,  halt: 1'b0};
            // wait here while the output register is held
            5'd18: o_uc = '{op: OP_DONE,  dst: DST_DAY,  shamt: 3'd0, target: PC_DONE,  halt: 1'b1};
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/sctd_seq.sv =====
// ----------------------------------------------------------------------------
// sctd_seq
// Step counter and jump logic. Takes one transaction when idle, runs the
// microprogram and returns to idle at the halting step.
// ----------------------------------------------------------------------------
`default_nettype none

module sctd_seq
    import sctd_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    output logic [PC_W-1:0]      o_pc,
    input  wire t_ucode          i_uc,
    input  wire t_stat           i_stat,
    output t_ctl                 o_ctl
);

    logic            r_busy, n_busy;
    logic [PC_W-1:0] r_pc, n_pc;
    logic            accept;

    assign accept     = i_in_valid && !r_busy;
    assign o_in_stall = r_busy;
    assign o_pc       = r_pc;

    assign o_ctl.busy = r_busy;
    assign o_ctl.load = accept;
    assign o_ctl.uc   = i_uc;

    // Next step: jump on condition, else halt or fall through
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (accept) begin
            n_busy = 1'b1;
            n_pc   = '0;
        end else if (r_busy) begin
            if (i_stat.cond) begin
                n_pc = i_uc.target;
            end else if (i_uc.halt) begin
                n_busy = 1'b0;
                n_pc   = '0;
            end else begin
                n_pc = r_pc + PC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    // Step counter stays inside the program
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc < PC_W'(UC_DEPTH)))
        else $error("sctd_seq: step counter outside program");

    // Idle counter always parks at the first step
    a_idle_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_pc == '0))
        else $error("sctd_seq: idle with nonzero step");

    // A halting step without its condition ends the run
    a_halt_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && i_uc.halt && !i_stat.cond) |=> !r_busy)
        else $error("sctd_seq: halt did not end the run");

endmodule

`default_nettype wire

// ===== sv/sctd_datapath.sv =====
// ----------------------------------------------------------------------------
// sctd_datapath
// Remainder register with one shared subtractor, year and month counters with
// leap tracking, quotient shift registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sctd_datapath
    import sctd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_ctl        i_ctl,
    output t_stat            o_stat,
    input  wire logic [31:0] i_seconds_count,
    input  wire logic        i_epoch_select,
    input  wire logic [16:0] i_zone,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [10:0]      o_year_value,
    output logic [3:0]       o_month_value,
    output logic [4:0]       o_day_value,
    output logic [4:0]       o_hour_value,
    output logic [5:0]       o_minute_value,
    output logic [5:0]       o_second_value
);

    logic [31:0] r_t, n_t;
    logic [10:0] r_year, n_year;
    logic [6:0]  r_mod100, n_mod100;
    logic [8:0]  r_mod400, n_mod400;
    logic [3:0]  r_month, n_month;
    logic [4:0]  r_day, n_day;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min, n_min;
    logic        r_out_valid, n_out_valid;

    logic        leap;
    logic [31:0] operand;
    logic [16:0] div_base;
    logic [32:0] diff;
    logic        ge;
    logic        out_blocked;
    logic        out_load;
    logic [31:0] start_t;

    // Gregorian leap rule from running residues
    assign leap = (r_year[1:0] == 2'd0) && ((r_mod100 != 7'd0) || (r_mod400 == 9'd0));

    // Starting count: epoch shift and sign-extended zone, both wrapping
    assign start_t = i_seconds_count
                   + (i_epoch_select ? EPOCH_SHIFT_UNIX : 32'd0)
                   + {{15{i_zone[16]}}, i_zone};

    // Subtrahend select
    always_comb begin
        case (i_ctl.uc.dst)
            DST_HOUR: div_base = SEC_PER_HOUR;
            DST_MIN:  div_base = SEC_PER_MIN;
            default:  div_base = SEC_PER_DAY;
        endcase
        case (i_ctl.uc.op)
            OP_YEAR:  operand = leap ? LEAP_YEAR_LEN : COMMON_YEAR_LEN;
            OP_MONTH: operand = 32'(month_secs(r_month, leap));
            OP_DIV:   operand = 32'(div_base) << i_ctl.uc.shamt;
            default:  operand = 32'd0;
        endcase
    end

    assign diff        = {1'b0, r_t} - {1'b0, operand};
    assign ge          = !diff[32];
    assign out_blocked = r_out_valid && i_out_stall;

    // Jump condition for the sequencer
    always_comb begin
        case (i_ctl.uc.op)
            OP_YEAR:  o_stat.cond = ge;
            OP_MONTH: o_stat.cond = (r_month != MONTH_DEC) && ge;
            OP_DONE:  o_stat.cond = out_blocked;
            default:  o_stat.cond = 1'b0;
        endcase
    end

    assign out_load = i_ctl.busy && (i_ctl.uc.op == OP_DONE) && !out_blocked;

    // Step execution
    always_comb begin
        n_t      = r_t;
        n_year   = r_year;
        n_mod100 = r_mod100;
        n_mod400 = r_mod400;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_min    = r_min;
        if (i_ctl.load) begin
            n_t      = start_t;
            n_year   = BASE_YEAR;
            n_mod100 = 7'd0;
            n_mod400 = BASE_MOD400;
            n_month  = MONTH_JAN;
            n_day    = '0;
            n_hour   = '0;
            n_min    = '0;
        end else if (i_ctl.busy) begin
            case (i_ctl.uc.op)
                OP_YEAR: begin
                    if (ge) begin
                        n_t      = diff[31:0];
                        n_year   = r_year + 11'd1;
                        n_mod100 = (r_mod100 == 7'd99)  ? 7'd0 : r_mod100 + 7'd1;
                        n_mod400 = (r_mod400 == 9'd399) ? 9'd0 : r_mod400 + 9'd1;
                    end
                end
                OP_MONTH: begin
                    if (o_stat.cond) begin
                        n_t     = diff[31:0];
                        n_month = r_month + 4'd1;
                    end
                end
                OP_DIV: begin
                    if (ge) begin
                        n_t = diff[31:0];
                    end
                    case (i_ctl.uc.dst)
                        DST_HOUR: n_hour = {r_hour[3:0], ge};
                        DST_MIN:  n_min  = {r_min[4:0], ge};
                        default:  n_day  = {r_day[3:0], ge};
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Output handshake
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers and result payload
    always_ff @(posedge i_clk) begin
        r_t      <= n_t;
        r_year   <= n_year;
        r_mod100 <= n_mod100;
        r_mod400 <= n_mod400;
        r_month  <= n_month;
        r_day    <= n_day;
        r_hour   <= n_hour;
        r_min    <= n_min;
        if (out_load) begin
            o_year_value   <= r_year;
            o_month_value  <= r_month;
            o_day_value    <= r_day + 5'd1;
            o_hour_value   <= r_hour;
            o_minute_value <= r_min;
            o_second_value <= r_t[5:0];
        end
    end

    assign o_out_valid = r_out_valid;

    // Month counter stays within the year during a run
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.busy |-> (r_month >= MONTH_JAN && r_month <= MONTH_DEC))
        else $error("sctd_datapath: month out of range");

    // Leap residues stay in range
    a_residues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.busy |-> (r_mod100 < 7'd100 && r_mod400 < 9'd400))
        else $error("sctd_datapath: leap residue out of range");

    // By hand-off the remainder is below one minute
    a_sec_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_t < 32'd60))
        else $error("sctd_datapath: remainder not reduced at hand-off");

endmodule

`default_nettype wire
